// ===== rtl/mmsf_pkg.sv =====
`timescale 1ns / 1ps

package mmsf_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int MODE_W     = 3;
  localparam int GAIN_W     = 8;
  localparam int LEN_W      = 13;
  localparam int HIST_W     = 16;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [MODE_W-1:0]     mode_t;

  localparam mode_t MODE_BYPASS   = 3'd0;
  localparam mode_t MODE_MEAN     = 3'd1;
  localparam mode_t MODE_LOWPASS  = 3'd2;
  localparam mode_t MODE_HIGHPASS = 3'd3;
  localparam mode_t MODE_ECHO     = 3'd4;

  localparam cfg_idx_t REG_MODE          = 3'd0;
  localparam cfg_idx_t REG_LOWPASS_GAIN  = 3'd1;
  localparam cfg_idx_t REG_HIGHPASS_GAIN = 3'd2;
  localparam cfg_idx_t REG_FEEDBACK_GAIN = 3'd3;
  localparam cfg_idx_t REG_ECHO_LENGTH   = 3'd4;

  localparam logic [LEN_W-1:0] ECHO_LENGTH_RESET = 13'd1;

  localparam sample_t LOWPASS_OFFSET  = 8'd1;
  localparam sample_t HIGHPASS_OFFSET = 8'd127;
  localparam sample_t OUT_OFFSET      = 8'd1;

endpackage

// ===== rtl/mmsf_in_if.sv =====
`timescale 1ns / 1ps

interface mmsf_in_if;
  import mmsf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ===== rtl/mmsf_out_if.sv =====
`timescale 1ns / 1ps

interface mmsf_out_if;
  import mmsf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== rtl/mmsf_cfg_if.sv =====
`timescale 1ns / 1ps

interface mmsf_cfg_if;
  import mmsf_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/multimode_audio_sample_filter.sv =====
`timescale 1ns / 1ps

// Multimode audio sample filter: one 8-bit sample in, one 8-bit sample out, at one sample per
// clock cycle sustained while the skid buffer is empty. Modes are bypass, two-tap mean,
// first-order low-pass and high-pass, and echo. The echo ring lives in a single ECHO_DEPTH x 8
// synchronous memory with one write and one read port; the read for the next sample is issued
// early from the next read pointer, and a write to the entry being read is forwarded. The IIR
// feedback path (two small multiplies and an add) closes through last_output. The store needs
// no clearing pass: a fill count marks written entries, so the block is ready right after
// reset and after any configuration write to registers 0 to 4, which zeroes all history.
// Results pass through an output register and a one-entry skid buffer, so input keeps flowing
// while one result waits. The configuration port is always ready; write it only while idle.
module multimode_audio_sample_filter #(
  parameter int ECHO_DEPTH = 4096
) (
  input logic          clk,
  input logic          rst,
  mmsf_in_if.sink      samples,
  mmsf_out_if.source   results,
  mmsf_cfg_if.sink     cfg
);
  import mmsf_pkg::*;

  localparam int AW = $clog2(ECHO_DEPTH);

  logic [MODE_W-1:0]        mode;
  logic [GAIN_W-1:0]        lowpass_gain;
  logic [GAIN_W-1:0]        highpass_gain;
  logic signed [GAIN_W-1:0] feedback_gain;
  logic [LEN_W-1:0]         echo_length;

  sample_t                  last_input;
  logic signed [HIST_W-1:0] last_output;
  logic [AW-1:0]            write_index;
  logic [AW-1:0]            read_index;
  logic [AW:0]              fill;

  logic [7:0]    echo_store [ECHO_DEPTH];
  sample_t       rd_q;
  logic          rd_valid;
  logic          byp_hit;
  sample_t       byp_data;

  sample_t       out_data;
  logic          out_valid;
  sample_t       skid_data;
  logic          skid_valid;

  logic          in_xfer;
  logic          cfg_xfer;
  logic          cfg_hit;
  logic          echo_xfer;
  sample_t       x;
  sample_t       old_sample;
  sample_t       res;

  logic [31:0]   len_wide;
  logic [AW:0]   len_eff;
  logic [AW:0]   r_inc;
  logic [AW-1:0] r_adv;
  logic [AW-1:0] read_index_next;
  logic [AW-1:0] write_index_next;
  logic [AW:0]   fill_next;

  logic [GAIN_W-1:0]   gain_sel;
  logic signed [9:0]   mix_in;
  logic signed [18:0]  prod_in;
  logic signed [23:0]  prod_fb;
  logic signed [24:0]  acc;
  logic [8:0]          mean_sum;
  logic [10:0]         echo_sum;

  assign x         = samples.sample_in;
  assign in_xfer   = samples.valid && samples.ready;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign cfg_hit   = cfg_xfer && (cfg.index <= REG_ECHO_LENGTH);
  assign echo_xfer = in_xfer && (mode == MODE_ECHO);

  assign samples.ready = !skid_valid;
  assign cfg.ready     = 1'b1;
  assign results.valid      = out_valid;
  assign results.sample_out = out_data;

  always_comb begin
    len_wide = 32'(echo_length);
    if (echo_length == '0) begin
      len_eff = (AW+1)'(1);
    end else if (len_wide > 32'(ECHO_DEPTH)) begin
      len_eff = (AW+1)'(ECHO_DEPTH);
    end else begin
      len_eff = len_wide[AW:0];
    end
    r_inc = {1'b0, read_index} + (AW+1)'(1);
    r_adv = (r_inc >= len_eff) ? '0 : r_inc[AW-1:0];
  end

  always_comb begin
    if (byp_hit) begin
      old_sample = byp_data;
    end else if (rd_valid) begin
      old_sample = rd_q;
    end else begin
      old_sample = '0;
    end
    if (write_index == read_index) begin
      old_sample = x;
    end
  end

  always_comb begin
    gain_sel = (mode == MODE_HIGHPASS) ? highpass_gain : lowpass_gain;
    if (mode == MODE_HIGHPASS) begin
      mix_in = $signed({2'b00, x}) - $signed({2'b00, last_input});
    end else begin
      mix_in = $signed({2'b00, x}) + $signed({2'b00, last_input});
    end
    prod_in  = $signed({1'b0, gain_sel}) * mix_in;
    prod_fb  = feedback_gain * last_output;
    acc      = 25'(prod_in) + 25'(prod_fb);
    mean_sum = {1'b0, x} + {1'b0, last_input};
    echo_sum = 11'(x) * 11'd5 + 11'(old_sample) * 11'd3;
  end

  always_comb begin
    unique case (mode)
      MODE_MEAN:     res = mean_sum[8:1];
      MODE_LOWPASS:  res = acc[14:7] + LOWPASS_OFFSET;
      MODE_HIGHPASS: res = acc[14:7] + HIGHPASS_OFFSET;
      MODE_ECHO:     res = echo_sum[10:3] + OUT_OFFSET;
      default:       res = x + OUT_OFFSET;
    endcase
  end

  always_comb begin
    read_index_next  = read_index;
    write_index_next = write_index;
    fill_next        = fill;
    if (cfg_hit) begin
      read_index_next  = '0;
      write_index_next = '0;
      fill_next        = '0;
    end else if (echo_xfer) begin
      read_index_next  = r_adv;
      write_index_next = read_index;
      if ({1'b0, write_index} == fill) begin
        fill_next = fill + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (echo_xfer && !cfg_hit) begin
      echo_store[write_index] <= x;
    end
    rd_q <= echo_store[read_index_next];
  end

  always_ff @(posedge clk) begin
    byp_data <= x;
    if (rst) begin
      byp_hit  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      byp_hit  <= echo_xfer && !cfg_hit && (read_index_next == write_index);
      rd_valid <= {1'b0, read_index_next} < fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_BYPASS;
      lowpass_gain  <= '0;
      highpass_gain <= '0;
      feedback_gain <= '0;
      echo_length   <= ECHO_LENGTH_RESET;
      last_input    <= '0;
      last_output   <= '0;
      write_index   <= '0;
      read_index    <= '0;
      fill          <= '0;
    end else begin
      read_index  <= read_index_next;
      write_index <= write_index_next;
      fill        <= fill_next;
      if (cfg_hit) begin
        unique case (cfg.index)
          REG_MODE:          mode          <= cfg.data[MODE_W-1:0];
          REG_LOWPASS_GAIN:  lowpass_gain  <= cfg.data[GAIN_W-1:0];
          REG_HIGHPASS_GAIN: highpass_gain <= cfg.data[GAIN_W-1:0];
          REG_FEEDBACK_GAIN: feedback_gain <= $signed(cfg.data[GAIN_W-1:0]);
          default:           echo_length   <= cfg.data[LEN_W-1:0];
        endcase
        last_input  <= '0;
        last_output <= '0;
      end else if (in_xfer) begin
        if (mode == MODE_MEAN || mode == MODE_LOWPASS || mode == MODE_HIGHPASS) begin
          last_input <= x;
        end
        if (mode == MODE_LOWPASS || mode == MODE_HIGHPASS) begin
          last_output <= acc[22:7];
        end
      end
    end
  end

  // hold a result in the skid stage while the output register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || results.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || results.ready) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (in_xfer && out_valid && !results.ready) begin
      skid_data <= res;
    end
  end

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (fill == '0 && read_index == '0 && write_index == '0 && !byp_hit))
    else $error("configuration write did not clear echo history");

  a_bypass_after_write: assert property (@(posedge clk) disable iff (rst)
    byp_hit |-> $past(echo_xfer))
    else $error("read forwarding without a preceding echo write");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= len_eff || $past(cfg_hit))
    else $error("fill count exceeds echo length");

  a_read_in_ring: assert property (@(posedge clk) disable iff (rst)
    echo_xfer |=> ({1'b0, read_index} < len_eff))
    else $error("read pointer left the echo ring");
`endif

endmodule
